// File: sv/i2cep_pkg.sv
// ---------------------------------------------------------------------------
// I2C EEPROM page master package
// Types, codes and constants shared by the front end, the bus engine and the
// top level.
// ---------------------------------------------------------------------------
package i2cep_pkg;

    localparam int DEV_ADDR_W   = 7;
    localparam int PHASE_W      = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 1'b1;

    localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET    = 7'd80;
    localparam logic [PHASE_W-1:0]    PHASE_TICKS_RESET = 16'd1;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [1:0] STATUS_NONE  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ABORT = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_LOAD,
        KIND_WRITE,
        KIND_READ
    } t_kind;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] mem_addr;
        logic [3:0] count;
        logic [2:0] slot;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic [7:0] read_byte;
        logic [2:0] read_slot;
        logic       read_valid;
        logic       busy_res;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] mem_addr;
        logic [3:0] total;
        logic [2:0] slot;
        logic       slot_ok;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_queue_item;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_write;

endpackage

// File: sv/i2cep_front.sv
// ---------------------------------------------------------------------------
// I2C EEPROM page master front end
// Accepts requests, classifies them and holds them in a two-entry queue for
// the bus engine.
// ---------------------------------------------------------------------------
module i2cep_front #(
    parameter int PAGE_BYTES = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  i2cep_pkg::t_in_item    i_in_data,
    output logic                   o_q_valid,
    input  logic                   i_q_pop,
    output i2cep_pkg::t_queue_item o_q_item
);

    localparam int CW = ($clog2(PAGE_BYTES + 1) > 4) ? $clog2(PAGE_BYTES + 1) : 4;

    i2cep_pkg::t_queue_item r_q [2];
    logic                   r_wptr;
    logic                   r_rptr;
    logic [1:0]             r_fill;

    i2cep_pkg::t_queue_item cls;
    logic [CW-1:0]          slot_ext;
    logic [CW-1:0]          count_ext;
    logic                   push;
    logic                   pop;

    always_comb begin
        slot_ext      = CW'(i_in_data.slot);
        count_ext     = CW'(i_in_data.count);
        cls.mem_addr  = i_in_data.mem_addr;
        cls.slot      = i_in_data.slot;
        cls.data_byte = i_in_data.data_byte;
        cls.sda_in    = i_in_data.sda_in;
        cls.slot_ok   = slot_ext < CW'(PAGE_BYTES);
        cls.total     = (count_ext > CW'(PAGE_BYTES)) ? 4'(PAGE_BYTES) : i_in_data.count;
        unique case (i_in_data.action)
            i2cep_pkg::ACT_TICK:  cls.kind = i2cep_pkg::KIND_TICK;
            i2cep_pkg::ACT_LOAD:  cls.kind = i2cep_pkg::KIND_LOAD;
            i2cep_pkg::ACT_WRITE: cls.kind = i2cep_pkg::KIND_WRITE;
            default:              cls.kind = i2cep_pkg::KIND_READ;
        endcase
    end

    assign o_in_ready = (r_fill != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && (r_fill != 2'd0);
    assign o_q_valid  = (r_fill != 2'd0);
    assign o_q_item   = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cls;
        end
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_fill <= r_fill + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: sv/i2cep_engine.sv
// ---------------------------------------------------------------------------
// I2C EEPROM page master bus engine
// Takes one queued request a cycle while its result register is free or read,
// steps the bus sequence and page buffer, and registers one result per request.
// ---------------------------------------------------------------------------
module i2cep_engine #(
    parameter int PAGE_BYTES = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  i2cep_pkg::t_cfg_write  i_cfg,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  i2cep_pkg::t_queue_item i_q_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output i2cep_pkg::t_out_item   o_out_data
);

    localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int CW = ($clog2(PAGE_BYTES + 1) > 4) ? $clog2(PAGE_BYTES + 1) : 4;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START1, ST_START2, ST_TXL, ST_TXH, ST_ACKL, ST_ACKH,
        ST_RXL, ST_RXH, ST_MAL, ST_MAH, ST_STOP1, ST_STOP2
    } t_step;

    typedef enum logic [1:0] {
        SG_DEVW, SG_MEM, SG_DATA, SG_DEVR
    } t_stage;

    logic [7:0] r_page [PAGE_BYTES];
    logic [7:0] r_rd;

    logic [i2cep_pkg::DEV_ADDR_W-1:0] r_dev_addr;
    logic [i2cep_pkg::PHASE_W-1:0]    r_phase_ticks;

    t_step      r_step,     n_step;
    t_stage     r_stage,    n_stage;
    logic [15:0] r_pc,      n_pc;
    logic [3:0] r_bit,      n_bit;
    logic [3:0] r_byte,     n_byte;
    logic [7:0] r_shift,    n_shift;
    logic [7:0] r_tgt,      n_tgt;
    logic [3:0] r_total,    n_total;
    logic       r_is_read,  n_is_read;
    logic       r_scl,      n_scl;
    logic       r_sda,      n_sda;
    logic       r_drive,    n_drive;
    logic       r_out_valid;
    i2cep_pkg::t_out_item r_out, n_out;

    logic        busy;
    logic        pop;
    logic [15:0] limit;
    logic [15:0] pc_inc;
    logic [3:0]  bit_inc;
    logic [3:0]  byte_inc;
    logic        do_send;
    logic [7:0]  send_val;
    logic        do_stop;
    logic        mem_we;
    logic [CW-1:0] rd_addr;
    logic [CW-1:0] wr_ext;
    logic [AW-1:0] rd_idx;
    logic [AW-1:0] wr_idx;

    assign busy    = (r_step != ST_IDLE);
    assign pop     = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop = pop;
    assign limit   = (r_phase_ticks == '0) ? 16'd1 : r_phase_ticks;
    assign pc_inc  = r_pc + 16'd1;
    assign bit_inc = r_bit + 4'd1;
    assign byte_inc = r_byte + 4'd1;

    assign rd_addr = (r_stage == SG_MEM) ? '0 : CW'(r_byte) + CW'(1);
    assign rd_idx  = (rd_addr < CW'(PAGE_BYTES)) ? rd_addr[AW-1:0] : '0;
    assign wr_ext  = CW'(i_q_item.slot);
    assign wr_idx  = wr_ext[AW-1:0];

    always_comb begin
        n_step    = r_step;
        n_stage   = r_stage;
        n_pc      = r_pc;
        n_bit     = r_bit;
        n_byte    = r_byte;
        n_shift   = r_shift;
        n_tgt     = r_tgt;
        n_total   = r_total;
        n_is_read = r_is_read;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_drive   = r_drive;
        do_send   = 1'b0;
        send_val  = r_tgt;
        do_stop   = 1'b0;
        mem_we    = 1'b0;
        n_out.read_byte  = 8'd0;
        n_out.read_slot  = 3'd0;
        n_out.read_valid = 1'b0;
        n_out.status     = i2cep_pkg::STATUS_NONE;

        unique case (i_q_item.kind)
            i2cep_pkg::KIND_TICK: begin
                if (busy) begin
                    if (pc_inc >= limit) begin
                        n_pc = 16'd0;
                        unique case (r_step)
                            ST_START1: begin
                                n_sda  = 1'b0;
                                n_step = ST_START2;
                            end
                            ST_START2: begin
                                do_send  = 1'b1;
                                send_val = {r_dev_addr, (r_stage == SG_DEVR)};
                            end
                            ST_TXL: begin
                                n_scl  = 1'b1;
                                n_step = ST_TXH;
                            end
                            ST_TXH: begin
                                n_scl = 1'b0;
                                n_bit = bit_inc;
                                if (bit_inc < i2cep_pkg::BITS_PER_BYTE) begin
                                    n_sda  = r_shift[3'(4'd7 - bit_inc)];
                                    n_step = ST_TXL;
                                end else begin
                                    n_drive = 1'b0;
                                    n_step  = ST_ACKL;
                                end
                            end
                            ST_ACKL: begin
                                n_scl   = 1'b1;
                                n_shift = {7'd0, i_q_item.sda_in};
                                n_step  = ST_ACKH;
                            end
                            ST_ACKH: begin
                                n_scl = 1'b0;
                                if (r_shift[0]) begin
                                    n_drive      = 1'b0;
                                    n_step       = ST_IDLE;
                                    n_out.status = i2cep_pkg::STATUS_ABORT;
                                end else begin
                                    unique case (r_stage)
                                        SG_DEVW: begin
                                            n_stage  = SG_MEM;
                                            do_send  = 1'b1;
                                            send_val = r_tgt;
                                        end
                                        SG_MEM: begin
                                            n_byte = 4'd0;
                                            if (r_is_read) begin
                                                n_scl   = 1'b1;
                                                n_sda   = 1'b1;
                                                n_drive = 1'b1;
                                                n_stage = SG_DEVR;
                                                n_step  = ST_START1;
                                            end else if (r_total != 4'd0) begin
                                                n_stage  = SG_DATA;
                                                do_send  = 1'b1;
                                                send_val = r_rd;
                                            end else begin
                                                do_stop = 1'b1;
                                            end
                                        end
                                        SG_DATA: begin
                                            n_byte = byte_inc;
                                            if (byte_inc < r_total) begin
                                                do_send  = 1'b1;
                                                send_val = r_rd;
                                            end else begin
                                                do_stop = 1'b1;
                                            end
                                        end
                                        default: begin
                                            n_byte = 4'd0;
                                            if (r_total != 4'd0) begin
                                                n_drive = 1'b0;
                                                n_bit   = 4'd0;
                                                n_shift = 8'd0;
                                                n_step  = ST_RXL;
                                            end else begin
                                                n_sda   = 1'b1;
                                                n_drive = 1'b1;
                                                n_step  = ST_MAL;
                                            end
                                        end
                                    endcase
                                end
                            end
                            ST_RXL: begin
                                n_scl   = 1'b1;
                                n_shift = {r_shift[6:0], i_q_item.sda_in};
                                n_step  = ST_RXH;
                            end
                            ST_RXH: begin
                                n_scl = 1'b0;
                                n_bit = bit_inc;
                                if (bit_inc < i2cep_pkg::BITS_PER_BYTE) begin
                                    n_step = ST_RXL;
                                end else begin
                                    n_out.read_valid = 1'b1;
                                    n_out.read_byte  = r_shift;
                                    n_out.read_slot  = r_byte[2:0];
                                    n_byte  = byte_inc;
                                    n_sda   = !(byte_inc < r_total);
                                    n_drive = 1'b1;
                                    n_step  = ST_MAL;
                                end
                            end
                            ST_MAL: begin
                                n_scl  = 1'b1;
                                n_step = ST_MAH;
                            end
                            ST_MAH: begin
                                n_scl = 1'b0;
                                if (r_byte < r_total) begin
                                    n_drive = 1'b0;
                                    n_bit   = 4'd0;
                                    n_shift = 8'd0;
                                    n_step  = ST_RXL;
                                end else begin
                                    do_stop = 1'b1;
                                end
                            end
                            ST_STOP1: begin
                                n_scl  = 1'b1;
                                n_step = ST_STOP2;
                            end
                            ST_STOP2: begin
                                n_sda        = 1'b1;
                                n_step       = ST_IDLE;
                                n_out.status = i2cep_pkg::STATUS_DONE;
                            end
                            default: begin
                                n_step = ST_IDLE;
                            end
                        endcase
                    end else begin
                        n_pc = pc_inc;
                    end
                end
            end
            i2cep_pkg::KIND_LOAD: begin
                mem_we = !busy && i_q_item.slot_ok;
            end
            default: begin
                if (!busy) begin
                    n_tgt     = i_q_item.mem_addr;
                    n_total   = i_q_item.total;
                    n_is_read = (i_q_item.kind == i2cep_pkg::KIND_READ);
                    n_byte    = 4'd0;
                    n_bit     = 4'd0;
                    n_shift   = 8'd0;
                    n_pc      = 16'd0;
                    n_stage   = SG_DEVW;
                    n_scl     = 1'b1;
                    n_sda     = 1'b1;
                    n_drive   = 1'b1;
                    n_step    = ST_START1;
                end
            end
        endcase

        if (do_send) begin
            n_shift = send_val;
            n_bit   = 4'd0;
            n_scl   = 1'b0;
            n_sda   = send_val[7];
            n_drive = 1'b1;
            n_step  = ST_TXL;
        end
        if (do_stop) begin
            n_scl   = 1'b0;
            n_sda   = 1'b0;
            n_drive = 1'b1;
            n_step  = ST_STOP1;
        end

        n_out.scl       = n_scl;
        n_out.sda_out   = n_sda;
        n_out.sda_drive = n_drive;
        n_out.busy_res  = (n_step != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (pop && mem_we) begin
            r_page[wr_idx] <= i_q_item.data_byte;
        end
        r_rd <= r_page[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_dev_addr    <= i2cep_pkg::DEV_ADDR_RESET;
            r_phase_ticks <= i2cep_pkg::PHASE_TICKS_RESET;
            r_step        <= ST_IDLE;
            r_stage       <= SG_DEVW;
            r_pc          <= 16'd0;
            r_bit         <= 4'd0;
            r_byte        <= 4'd0;
            r_shift       <= 8'd0;
            r_tgt         <= 8'd0;
            r_total       <= 4'd0;
            r_is_read     <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_drive       <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    i2cep_pkg::CFG_DEVICE_ADDRESS:
                        r_dev_addr <= i_cfg.data[i2cep_pkg::DEV_ADDR_W-1:0];
                    default:
                        r_phase_ticks <= i_cfg.data[i2cep_pkg::PHASE_W-1:0];
                endcase
            end
            if (pop) begin
                r_step    <= n_step;
                r_stage   <= n_stage;
                r_pc      <= n_pc;
                r_bit     <= n_bit;
                r_byte    <= n_byte;
                r_shift   <= n_shift;
                r_tgt     <= n_tgt;
                r_total   <= n_total;
                r_is_read <= n_is_read;
                r_scl     <= n_scl;
                r_sda     <= n_sda;
                r_drive   <= n_drive;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: sv/i2c_eeprom_page_master.sv
// ---------------------------------------------------------------------------
// I2C EEPROM page master
// Page write and page read master for a serial EEPROM, paced by tick
// requests; a front queue feeds a bus engine that returns one result each.
// ---------------------------------------------------------------------------
// Order: a taken request is written into the front queue, then popped by the
// bus engine, which registers its result in the output register.
// Throughput: one request per cycle while the output register is free or being
// accepted, set by the bus engine taking one queued request a cycle into it.
// Reset: synchronous, active low; the bus idles high and the page buffer is
// left as it was, with no clearing pass.
module i2c_eeprom_page_master #(
    parameter int PAGE_BYTES = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  i2cep_pkg::t_in_item                   i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output i2cep_pkg::t_out_item                  o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [i2cep_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [i2cep_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic                   q_valid;
    logic                   q_pop;
    i2cep_pkg::t_queue_item q_item;
    i2cep_pkg::t_cfg_write  cfg;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    i2cep_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_item   (q_item)
    );

    i2cep_engine #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_item    (q_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    a_rx_byte_mid_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.read_valid) |-> o_out_data.busy_res)
        else $error("received byte reported outside a transfer");

    a_status_ends_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != i2cep_pkg::STATUS_NONE))
            |-> !o_out_data.busy_res)
        else $error("status reported while still busy");

    a_abort_leaves_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == i2cep_pkg::STATUS_ABORT))
            |-> (!o_out_data.scl && !o_out_data.sda_drive))
        else $error("abort did not leave SCL low and SDA released");

    a_queue_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> q_valid)
        else $error("input stalled with an empty queue");
`endif

endmodule
